// ===== rtl/core/gwp_pkg.sv =====
package gwp_pkg;

  localparam logic [7:0] ChSemi   = 8'h3B;
  localparam logic [7:0] ChParen  = 8'h28;
  localparam logic [7:0] ChPoint  = 8'h2E;
  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChSpace  = 8'h20;

  typedef struct packed {
    logic [7:0] ch;
    logic       line_end;
  } gwp_req_t;

  typedef struct packed {
    logic [7:0]         word_letter;
    logic signed [31:0] word_value;
    logic [4:0]         word_index;
    logic               word_valid;
    logic               command_end;
  } gwp_res_t;

  // up to two results produced by one character
  typedef struct packed {
    logic [1:0] cnt;
    gwp_res_t   res0;
    gwp_res_t   res1;
  } gwp_push_t;

  // acc * 10 + d, saturated to 2^31-1
  function automatic logic [30:0] mul10_add(input logic [30:0] acc, input logic [3:0] d);
    logic [34:0] t;
    t = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {31'b0, d};
    return (t[34:31] != 4'b0) ? 31'h7FFF_FFFF : t[30:0];
  endfunction

  function automatic logic [13:0] pow10(input logic [2:0] k);
    logic [13:0] p;
    case (k)
      3'd0:    p = 14'd1;
      3'd1:    p = 14'd10;
      3'd2:    p = 14'd100;
      3'd3:    p = 14'd1000;
      default: p = 14'd10000;
    endcase
    return p;
  endfunction

endpackage

// ===== rtl/core/gwp_scan.sv =====
module gwp_scan import gwp_pkg::*; #(
  parameter int MAX_WORDS   = 20,
  parameter int FRAC_DIGITS = 3
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      fire_i,
  input  gwp_req_t  req_i,
  output gwp_push_t push_o
);

  localparam int FracW = (FRAC_DIGITS > 0) ? $clog2(FRAC_DIGITS + 1) : 1;
  localparam int CntW  = $clog2(MAX_WORDS + 1);

  localparam logic [2:0] PhIdle = 3'd0;
  localparam logic [2:0] PhLead = 3'd1;
  localparam logic [2:0] PhSign = 3'd2;
  localparam logic [2:0] PhInt  = 3'd3;
  localparam logic [2:0] PhFrac = 3'd4;
  localparam logic [2:0] PhSkip = 3'd5;
  localparam logic [2:0] PhDrop = 3'd6;

  logic [2:0]       phase_q, phase_d;
  logic [7:0]       letter_q, letter_d;
  logic [30:0]      acc_q, acc_d;
  logic             neg_q, neg_d;
  logic [FracW-1:0] frac_q, frac_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  logic [7:0]       c;
  logic             last, is_dig, is_let, is_sg, is_pt, skipc;
  logic [30:0]      acc_nx;
  logic [2:0]       phase1, phase2;
  logic [30:0]      acc1, acc2;
  logic             neg1, neg2;
  logic [FracW-1:0] frac1, frac2;
  logic [7:0]       letter2;
  logic [CntW-1:0]  cnt2;
  logic             in_word1, e2, e3, go_idle, at_limit;
  logic [30:0]      s_acc;
  logic [FracW-1:0] s_frac;
  logic             s_neg;
  logic [2:0]       s_rem;
  logic [44:0]      prod;
  logic [30:0]      mag;
  logic signed [31:0] val;
  gwp_res_t         word_a, word_b, empty_r;

  always_comb begin
    c      = req_i.ch;
    last   = req_i.line_end;
    is_dig = (c >= 8'h30) && (c <= 8'h39);
    is_let = ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    is_sg  = (c == ChPlus) || (c == ChMinus);
    is_pt  = (c == ChPoint);
    skipc  = is_dig || is_pt || is_sg || (c == ChSpace);
    acc_nx = mul10_add(acc_q, c[3:0]);

    phase1 = phase_q;
    acc1   = acc_q;
    neg1   = neg_q;
    frac1  = frac_q;
    unique case (phase_q)
      PhLead: begin
        if (is_sg) begin
          neg1   = (c == ChMinus);
          phase1 = PhSign;
        end else if (is_dig) begin
          acc1   = acc_nx;
          phase1 = PhInt;
        end else if (is_pt) begin
          phase1 = PhFrac;
        end
      end
      PhSign, PhInt: begin
        if (is_dig) begin
          acc1   = acc_nx;
          phase1 = PhInt;
        end else if (is_pt) begin
          phase1 = PhFrac;
        end else if (skipc) begin
          phase1 = PhSkip;
        end
      end
      PhFrac: begin
        if (is_dig) begin
          if (frac_q < FracW'(FRAC_DIGITS)) begin
            acc1  = acc_nx;
            frac1 = frac_q + 1'b1;
          end
        end else if (skipc) begin
          phase1 = PhSkip;
        end
      end
      default: ;
    endcase

    in_word1 = (phase1 >= PhLead) && (phase1 <= PhSkip);
    e2       = in_word1 && !skipc;
    at_limit = ({1'b0, cnt_q} + 1'b1) >= (CntW + 1)'(MAX_WORDS);
    cnt2     = cnt_q + CntW'(e2);
    go_idle  = e2 ? !at_limit : (phase1 == PhIdle);

    acc2    = acc1;
    neg2    = neg1;
    frac2   = frac1;
    letter2 = letter_q;
    if (e2) begin
      phase2 = at_limit ? PhDrop : PhIdle;
    end else if (phase1 > PhDrop) begin
      phase2 = PhDrop;
    end else begin
      phase2 = phase1;
    end
    if (go_idle) begin
      if ((c == ChSemi) || (c == ChParen)) begin
        phase2 = PhDrop;
      end else if (is_let) begin
        phase2  = PhLead;
        letter2 = c;
        acc2    = '0;
        neg2    = 1'b0;
        frac2   = '0;
      end
    end
    e3 = last && (phase2 >= PhLead) && (phase2 <= PhSkip);

    s_acc  = e2 ? acc1 : acc2;
    s_frac = e2 ? frac1 : frac2;
    s_neg  = e2 ? neg1 : neg2;
    s_rem  = 3'(FRAC_DIGITS) - 3'(s_frac);
    prod   = {14'b0, s_acc} * {31'b0, pow10(s_rem)};
    mag    = (prod[44:31] != 14'b0) ? 31'h7FFF_FFFF : prod[30:0];
    val    = s_neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

    word_a.word_letter = letter_q;
    word_a.word_value  = val;
    word_a.word_index  = 5'(cnt_q);
    word_a.word_valid  = 1'b1;
    word_a.command_end = last && !e3;

    word_b.word_letter = letter2;
    word_b.word_value  = e2 ? 32'sd0 : val;
    word_b.word_index  = 5'(cnt2);
    word_b.word_valid  = 1'b1;
    word_b.command_end = 1'b1;

    empty_r             = '0;
    empty_r.command_end = 1'b1;

    push_o.res1 = word_b;
    if (e2) begin
      push_o.res0 = word_a;
      push_o.cnt  = e3 ? 2'd2 : 2'd1;
    end else if (e3) begin
      push_o.res0 = word_b;
      push_o.cnt  = 2'd1;
    end else begin
      push_o.res0 = empty_r;
      push_o.cnt  = last ? 2'd1 : 2'd0;
    end

    if (last) begin
      phase_d  = PhIdle;
      letter_d = '0;
      acc_d    = '0;
      neg_d    = 1'b0;
      frac_d   = '0;
      cnt_d    = '0;
    end else begin
      phase_d  = phase2;
      letter_d = letter2;
      acc_d    = acc2;
      neg_d    = neg2;
      frac_d   = frac2;
      cnt_d    = cnt2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhIdle;
      letter_q <= '0;
      acc_q    <= '0;
      neg_q    <= 1'b0;
      frac_q   <= '0;
      cnt_q    <= '0;
    end else if (fire_i) begin
      phase_q  <= phase_d;
      letter_q <= letter_d;
      acc_q    <= acc_d;
      neg_q    <= neg_d;
      frac_q   <= frac_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ===== rtl/core/gcode_word_parser_unit.sv =====
// G-code word parser.
// Input channel: one character request per handshake (in_valid_i / in_stall_o),
// with line_end set on the last character of a line.
// Output channel: one word result per handshake (out_valid_o / out_stall_i).
// A character yields zero, one or two results; a line end always yields at
// least one, the last of the line carrying command_end.
// Each result is registered into the queue when its character is taken.
// Throughput: one character per cycle unless in_stall_o; results leave at one per
// cycle unless out_stall_i, so a character with two results needs two pops.
// Results wait in a four-entry queue; in_stall_o rises while fewer than two
// entries are free, so a stalled receiver backs up into the input channel.
// Held results never change while out_stall_i is high.
// Reset empties the queue and returns the scanner to the start of a line.
module gcode_word_parser_unit import gwp_pkg::*; #(
  parameter int MAX_WORDS   = 20,
  parameter int FRAC_DIGITS = 3
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  gwp_req_t in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output gwp_res_t out_res_o
);

  localparam int Depth = 4;
  localparam int PtrW  = $clog2(Depth);

  gwp_push_t     push;
  logic          fire, pop;
  logic [1:0]    push_n;
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [PtrW:0]   count_q, count_d;
  gwp_res_t      mem_q [Depth];

  assign in_stall_o  = count_q > (PtrW + 1)'(Depth - 2);
  assign fire        = in_valid_i && !in_stall_o;
  assign out_valid_o = count_q != '0;
  assign pop         = out_valid_o && !out_stall_i;
  assign out_res_o   = mem_q[rptr_q];

  gwp_scan #(
    .MAX_WORDS  (MAX_WORDS),
    .FRAC_DIGITS(FRAC_DIGITS)
  ) u_scan (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .fire_i(fire),
    .req_i (in_req_i),
    .push_o(push)
  );

  always_comb begin
    push_n  = fire ? push.cnt : 2'd0;
    wptr_d  = wptr_q + PtrW'(push_n);
    rptr_d  = rptr_q + PtrW'(pop);
    count_d = count_q + (PtrW + 1)'(push_n) - (PtrW + 1)'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      mem_q[wptr_q] <= push.res0;
    end
    if (push_n == 2'd2) begin
      mem_q[wptr_q + 1'b1] <= push.res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import gwp_pkg::*;

  localparam int MaxWords      = 20;
  localparam int FracDigits    = 3;
  localparam int DrainCycles   = 4;
  localparam int WatchdogLimit = 4000;

  localparam logic [7:0] ChZero   = "0";
  localparam logic [7:0] ChNine   = "9";
  localparam logic [7:0] ChUpperA = "A";
  localparam logic [7:0] ChUpperZ = "Z";
  localparam logic [7:0] ChLowerA = "a";
  localparam logic [7:0] ChLowerZ = "z";
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChClose  = 8'h29;

  typedef enum logic [2:0] {
    PhIdle, PhLead, PhSign, PhInt, PhFrac, PhSkip, PhDrop
  } scan_phase_e;

  logic     clk_i;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  gwp_req_t in_req_i    = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  gwp_res_t out_res_o;

  gcode_word_parser_unit #(
    .MAX_WORDS  (MaxWords),
    .FRAC_DIGITS(FracDigits)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_res_o  (out_res_o)
  );

  // scanner state of the predictor
  scan_phase_e scan_q   = PhIdle;
  logic [7:0]  letter_q = '0;
  logic [31:0] accum_q  = '0;
  logic        neg_q    = 1'b0;
  int          frac_q   = 0;
  int          count_q  = 0;

  gwp_res_t   step_words[$];
  gwp_res_t   expected_words[$];
  logic [7:0] line_chars[$];
  gwp_res_t   exp_w;

  int send_gap_pct = 0;
  int stall_pct    = 0;
  int errors       = 0;
  int lines_sent   = 0;
  int chars_sent   = 0;
  int results_seen = 0;
  int words_seen   = 0;
  int idle_cycles  = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic is_digit(input logic [7:0] c);
    return c >= ChZero && c <= ChNine;
  endfunction

  function automatic logic [31:0] mac10(input logic [31:0] acc, input logic [3:0] d);
    logic [63:0] t;
    t = {32'b0, acc} * 64'd10 + {60'b0, d};
    return (t > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : t[31:0];
  endfunction

  task automatic emit_word();
    logic [31:0] mag;
    gwp_res_t    w;
    mag = accum_q;
    for (int k = frac_q; k < FracDigits; k++) mag = mac10(mag, 4'd0);
    w.word_letter = letter_q;
    w.word_value  = neg_q ? -mag : mag;
    w.word_index  = count_q[4:0];
    w.word_valid  = 1'b1;
    w.command_end = 1'b0;
    step_words.push_back(w);
    count_q++;
    scan_q = (count_q >= MaxWords) ? PhDrop : PhIdle;
  endtask

  task automatic start_word(input logic [7:0] c);
    if (c == ChSemi || c == ChParen) begin
      scan_q = PhDrop;
    end else if ((c >= ChUpperA && c <= ChUpperZ) || (c >= ChLowerA && c <= ChLowerZ)) begin
      scan_q   = PhLead;
      letter_q = c;
      accum_q  = '0;
      neg_q    = 1'b0;
      frac_q   = 0;
    end
  endtask

  task automatic predict_char(input gwp_req_t r);
    logic [7:0] c;
    logic       dig;
    logic       skip_c;
    gwp_res_t   w;
    c      = r.ch;
    dig    = is_digit(c);
    skip_c = dig || c == ChPoint || c == ChSpace || c == ChPlus || c == ChMinus;
    step_words.delete();
    case (scan_q)
      PhLead: begin
        if (c == ChPlus || c == ChMinus) begin
          neg_q  = (c == ChMinus);
          scan_q = PhSign;
        end else if (dig) begin
          accum_q = mac10(accum_q, c[3:0]);
          scan_q  = PhInt;
        end else if (c == ChPoint) begin
          scan_q = PhFrac;
        end
      end
      PhSign, PhInt: begin
        if (dig) begin
          accum_q = mac10(accum_q, c[3:0]);
          scan_q  = PhInt;
        end else if (c == ChPoint) begin
          scan_q = PhFrac;
        end else if (skip_c) begin
          scan_q = PhSkip;
        end
      end
      PhFrac: begin
        if (dig) begin
          if (frac_q < FracDigits) begin
            accum_q = mac10(accum_q, c[3:0]);
            frac_q++;
          end
        end else if (skip_c) begin
          scan_q = PhSkip;
        end
      end
      default: ;
    endcase

    if (scan_q != PhIdle && scan_q != PhDrop && !skip_c) begin
      emit_word();
      if (scan_q == PhIdle) start_word(c);
    end else if (scan_q == PhIdle) begin
      start_word(c);
    end

    if (r.line_end) begin
      if (scan_q != PhIdle && scan_q != PhDrop) emit_word();
      if (step_words.size() == 0) begin
        w = '0;
        step_words.push_back(w);
      end
      w = step_words.pop_back();
      w.command_end = 1'b1;
      step_words.push_back(w);
      scan_q   = PhIdle;
      letter_q = '0;
      accum_q  = '0;
      neg_q    = 1'b0;
      frac_q   = 0;
      count_q  = 0;
    end
    foreach (step_words[i]) expected_words.push_back(step_words[i]);
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= rst_ni && ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) predict_char(in_req_i);
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (out_res_o.word_valid === 1'b1) words_seen++;
        if (expected_words.size() == 0) begin
          $error("unexpected result: letter %0h value %0d", out_res_o.word_letter,
                 out_res_o.word_value);
          errors++;
        end else begin
          exp_w = expected_words.pop_front();
          if (out_res_o.word_letter !== exp_w.word_letter) begin
            $error("word_letter: expected %0h, got %0h", exp_w.word_letter,
                   out_res_o.word_letter);
            errors++;
          end
          if (out_res_o.word_value !== exp_w.word_value) begin
            $error("word_value: expected %0d, got %0d", exp_w.word_value,
                   out_res_o.word_value);
            errors++;
          end
          if (out_res_o.word_index !== exp_w.word_index) begin
            $error("word_index: expected %0d, got %0d", exp_w.word_index,
                   out_res_o.word_index);
            errors++;
          end
          if (out_res_o.word_valid !== exp_w.word_valid) begin
            $error("word_valid: expected %0b, got %0b", exp_w.word_valid,
                   out_res_o.word_valid);
            errors++;
          end
          if (out_res_o.command_end !== exp_w.command_end) begin
            $error("command_end: expected %0b, got %0b", exp_w.command_end,
                   out_res_o.command_end);
            errors++;
          end
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WatchdogLimit) begin
          $display("timeout: no handshake for %0d cycles", WatchdogLimit);
          $display("status: fail");
          $finish;
        end
      end
    end
  end

  task automatic send_char(input logic [7:0] c, input logic last);
    gwp_req_t r;
    r.ch       = c;
    r.line_end = last;
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    chars_sent++;
  endtask

  task automatic send_line();
    foreach (line_chars[i]) send_char(line_chars[i], i == line_chars.size() - 1);
    lines_sent++;
  endtask

  // the first edges let the monitor register the last request before the queue is polled
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    repeat (DrainCycles) @(posedge clk_i);
    while (expected_words.size() != 0) @(posedge clk_i);
  endtask

  task automatic load_text(input string s);
    line_chars.delete();
    for (int i = 0; i < s.len(); i++) line_chars.push_back(s[i]);
  endtask

  // letter, optional spaces and sign, digits, optional fraction, trailing skip chars
  task automatic append_word();
    int n_int;
    if ($urandom_range(0, 1)) line_chars.push_back(ChUpperA + 8'($urandom_range(0, 25)));
    else line_chars.push_back(ChLowerA + 8'($urandom_range(0, 25)));
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 2)) line_chars.push_back(ChSpace);
    end
    if ($urandom_range(0, 2) == 0) line_chars.push_back($urandom_range(0, 1) ? ChMinus : ChPlus);
    case ($urandom_range(0, 9))
      0:       n_int = 0;
      9:       n_int = $urandom_range(7, 11);
      default: n_int = $urandom_range(1, 4);
    endcase
    repeat (n_int) line_chars.push_back(ChZero + 8'($urandom_range(0, 9)));
    if ($urandom_range(0, 2) == 0) begin
      line_chars.push_back(ChPoint);
      repeat ($urandom_range(0, 5)) line_chars.push_back(ChZero + 8'($urandom_range(0, 9)));
    end
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 4))
        0:       line_chars.push_back(ChSpace);
        1:       line_chars.push_back(ChPoint);
        2:       line_chars.push_back(ChPlus);
        3:       line_chars.push_back(ChMinus);
        default: line_chars.push_back(ChZero + 8'($urandom_range(0, 9)));
      endcase
    end
    if ($urandom_range(0, 1)) line_chars.push_back(ChSpace);
  endtask

  task automatic test_directed_cases();
    line_chars = '{8'hFF};
    send_line();
    line_chars = '{8'h00, ChClose, "A", ChMinus, ChPoint, ChTab, "B", ChPlus, ChMinus, "C",
                   ChSemi, "D"};
    send_line();
    load_text("X5Y");
    send_line();
    load_text("y2147484");
    send_line();
    wait_drained();
  endtask

  task automatic test_random_lines(input int n_chars);
    int stop_at;
    stop_at = chars_sent + n_chars;
    while (chars_sent < stop_at) begin
      line_chars.delete();
      if ($urandom_range(0, 5) == 0) line_chars.push_back(8'($urandom_range(0, 255)));
      repeat ($urandom_range(0, 5)) append_word();
      foreach (line_chars[i]) begin
        if ($urandom_range(0, 24) == 0) line_chars[i] = 8'($urandom_range(0, 255));
      end
      if (line_chars.size() != 0 && $urandom_range(0, 9) == 0)
        line_chars[$urandom_range(0, line_chars.size() - 1)] = ChTab;
      if ($urandom_range(0, 7) == 0) begin
        line_chars.push_back($urandom_range(0, 1) ? ChSemi : ChParen);
        repeat ($urandom_range(0, 4)) line_chars.push_back(8'($urandom_range(0, 255)));
      end
      if (line_chars.size() == 0) line_chars.push_back(8'($urandom_range(0, 255)));
      send_line();
    end
    wait_drained();
  endtask

  task automatic test_word_limit();
    repeat (2) begin
      line_chars.delete();
      repeat ($urandom_range(MaxWords, MaxWords + 6)) append_word();
      send_line();
    end
    wait_drained();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_gap_pct = 10;
    stall_pct    = 79;
    test_directed_cases();
    test_random_lines(250);

    send_gap_pct = 79;
    stall_pct    = 10;
    test_random_lines(250);

    send_gap_pct = 0;
    stall_pct    = 0;
    test_random_lines(150);
    test_word_limit();

    $display("sent %0d lines (%0d characters) under three idle/stall mixes", lines_sent,
             chars_sent);
    $display("checked %0d results, %0d of them words, %0d mismatches", results_seen,
             words_seen, errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
